>>> design/irpp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IMU RVC parser package
// Shared types and constants for the serial frame parser.
// ----------------------------------------------------------------------------
package irpp_pkg;

   // Byte and field widths
   localparam int BYTE_W   = 8;
   localparam int RAW_W    = 16;
   localparam int POS_W    = 5;
   localparam int IDX_W    = 4;

   // Frame layout
   localparam logic [BYTE_W-1:0] HDR_BYTE = 8'hAA;
   localparam logic [POS_W-1:0]  SUM_LEN  = 5'd16;
   localparam int                CHAN_BYTES = 12;

   // Frame queue between front and back
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef logic [BYTE_W-1:0]       byte_type;
   typedef logic signed [RAW_W-1:0] raw_type;
   typedef logic [RAW_W-1:0]        count_type;
   typedef logic [POS_W-1:0]        pos_type;
   typedef logic [IDX_W-1:0]        idx_type;

   typedef enum logic [1:0] {
      PH_HUNT1 = 2'd0,
      PH_HUNT2 = 2'd1,
      PH_BODY  = 2'd2
   } phase_type;

   // Six channels of one good frame
   typedef struct packed {
      raw_type yaw_raw;
      raw_type pitch_raw;
      raw_type roll_raw;
      raw_type accel_x_raw;
      raw_type accel_y_raw;
      raw_type accel_z_raw;
   } frame_type;

   // Front to queue
   typedef struct packed {
      logic      valid;
      frame_type frame;
   } push_type;

   // Queue status
   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage
`default_nettype wire

>>> design/irpp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IMU RVC parser channels
// Valid/ready channels for received bytes and decoded frames.
// ----------------------------------------------------------------------------
interface irpp_req_if;
   logic               valid;
   logic               ready;
   irpp_pkg::byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface irpp_rsp_if;
   logic                valid;
   logic                ready;
   irpp_pkg::raw_type   yaw_raw;
   irpp_pkg::raw_type   pitch_raw;
   irpp_pkg::raw_type   roll_raw;
   irpp_pkg::raw_type   accel_x_raw;
   irpp_pkg::raw_type   accel_y_raw;
   irpp_pkg::raw_type   accel_z_raw;
   irpp_pkg::count_type good_packets;

   modport source (output valid, output yaw_raw, output pitch_raw, output roll_raw,
                   output accel_x_raw, output accel_y_raw, output accel_z_raw,
                   output good_packets, input ready);
   modport sink   (input valid, input yaw_raw, input pitch_raw, input roll_raw,
                   input accel_x_raw, input accel_y_raw, input accel_z_raw,
                   input good_packets, output ready);
endinterface
`default_nettype wire

>>> design/irpp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IMU RVC parser front end
// Header hunt, payload capture and checksum; pushes good frames.
// ----------------------------------------------------------------------------
module irpp_front (
   input  wire                 clock,
   input  wire                 reset,
   irpp_req_if.sink            req_if,
   input  wire                 fifo_full,
   output irpp_pkg::push_type  push
);
   import irpp_pkg::*;

   phase_type phase_ff, phase_in;
   pos_type   pos_ff, pos_in;
   byte_type  sum_ff, sum_in;
   byte_type  bytes_ff [CHAN_BYTES];
   logic      take;
   logic      store_en;
   idx_type   store_idx;

   // Accept whenever a finished frame has room to go
   assign req_if.ready = !fifo_full;
   assign take         = req_if.valid && req_if.ready;

   // Next state
   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      sum_in   = sum_ff;
      if (take) begin
         case (phase_ff)
            PH_HUNT2: begin
               if (req_if.rx_byte == HDR_BYTE) begin
                  phase_in = PH_BODY;
                  pos_in   = '0;
                  sum_in   = '0;
               end else begin
                  phase_in = PH_HUNT1;
               end
            end
            PH_BODY: begin
               if (pos_ff < SUM_LEN) begin
                  sum_in = sum_ff + req_if.rx_byte;
                  pos_in = pos_ff + 1'b1;
               end else begin
                  // checksum byte ends the frame either way
                  phase_in = PH_HUNT1;
                  pos_in   = '0;
                  sum_in   = '0;
               end
            end
            default: begin
               // unused phase code behaves as the first hunt
               if (req_if.rx_byte == HDR_BYTE) begin
                  phase_in = PH_HUNT2;
               end else begin
                  phase_in = PH_HUNT1;
               end
            end
         endcase
      end
   end

   // Outputs: byte capture and frame push, little-endian channel pairs
   always_comb begin
      store_en   = 1'b0;
      push.valid = 1'b0;
      push.frame.yaw_raw     = {bytes_ff[1],  bytes_ff[0]};
      push.frame.pitch_raw   = {bytes_ff[3],  bytes_ff[2]};
      push.frame.roll_raw    = {bytes_ff[5],  bytes_ff[4]};
      push.frame.accel_x_raw = {bytes_ff[7],  bytes_ff[6]};
      push.frame.accel_y_raw = {bytes_ff[9],  bytes_ff[8]};
      push.frame.accel_z_raw = {bytes_ff[11], bytes_ff[10]};
      if (take && phase_ff == PH_BODY) begin
         store_en   = pos_ff inside {[5'd1:5'd12]};
         push.valid = (pos_ff >= SUM_LEN) && (req_if.rx_byte == sum_ff);
      end
   end

   assign store_idx = pos_ff[IDX_W-1:0] - 1'b1;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT1;
         pos_ff   <= '0;
         sum_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         sum_ff   <= sum_in;
      end
   end

   // Channel byte store, no reset
   always_ff @(posedge clock) begin
      if (store_en) begin
         bytes_ff[store_idx] <= req_if.rx_byte;
      end
   end

endmodule
`default_nettype wire

>>> design/irpp_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IMU RVC parser frame queue
// Short queue of decoded frames between front and back end.
// ----------------------------------------------------------------------------
module irpp_fifo (
   input  wire                         clock,
   input  wire                         reset,
   input  irpp_pkg::push_type          push,
   input  wire                         pop,
   output irpp_pkg::frame_type         head,
   output irpp_pkg::fifo_status_type   status
);
   import irpp_pkg::*;

   frame_type                mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]    count_ff, count_in;
   logic                     do_push;
   logic                     do_pop;

   assign status.full  = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push.valid && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = mem_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.frame;
      end
   end

endmodule
`default_nettype wire

>>> design/irpp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IMU RVC parser back end
// Counts good frames and holds the result item for the receiver.
// ----------------------------------------------------------------------------
module irpp_back (
   input  wire                         clock,
   input  wire                         reset,
   input  irpp_pkg::frame_type         head,
   input  irpp_pkg::fifo_status_type   status,
   output logic                        pop,
   irpp_rsp_if.source                  rsp_if
);
   import irpp_pkg::*;

   logic      valid_ff, valid_in;
   frame_type frame_ff;
   count_type total_ff, total_in;

   // Take the next frame when the output register is free or draining
   assign pop      = !status.empty && (!valid_ff || rsp_if.ready);
   assign valid_in = pop ? 1'b1 : (valid_ff && !rsp_if.ready);
   assign total_in = pop ? total_ff + 1'b1 : total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         total_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         frame_ff <= head;
      end
   end

   assign rsp_if.valid        = valid_ff;
   assign rsp_if.yaw_raw      = frame_ff.yaw_raw;
   assign rsp_if.pitch_raw    = frame_ff.pitch_raw;
   assign rsp_if.roll_raw     = frame_ff.roll_raw;
   assign rsp_if.accel_x_raw  = frame_ff.accel_x_raw;
   assign rsp_if.accel_y_raw  = frame_ff.accel_y_raw;
   assign rsp_if.accel_z_raw  = frame_ff.accel_z_raw;
   assign rsp_if.good_packets = total_ff;

endmodule
`default_nettype wire

>>> design/imu_rvc_packet_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IMU RVC packet parser
// Turns a stream of received serial bytes into decoded RVC frames.
// ----------------------------------------------------------------------------
// Usage:
//  - req_if carries one received byte per item. A frame is two 0xAA header
//    bytes and 17 payload bytes; the last payload byte is the 8-bit sum of
//    the first sixteen.
//  - rsp_if carries one item per frame with a good checksum: six signed
//    little-endian channels and the running good-frame count. Bad frames
//    are dropped silently.
//  - One byte is taken per cycle while the queue is not full. The result item
//    becomes valid after the checksum byte is accepted: the front end writes
//    the frame into the queue at the accepting edge, and the back end output
//    register loads it from the queue once that register is free or draining.
//  - A two-entry frame queue separates parser and output register. If the
//    receiver stalls, the parser keeps taking bytes; req_if.ready drops only
//    while the queue is full, which needs two more good frames waiting
//    behind a stalled result item.
//  - Reset returns the parser to the header hunt, empties the queue and
//    clears the frame count.
// ----------------------------------------------------------------------------
module imu_rvc_packet_parser (
   input  wire          clock,
   input  wire          reset,
   irpp_req_if.sink     req_if,
   irpp_rsp_if.source   rsp_if
);
   import irpp_pkg::*;

   push_type        push;
   frame_type       head;
   fifo_status_type fifo_status;
   logic            pop;

   irpp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .fifo_full (fifo_status.full),
      .push      (push)
   );

   irpp_fifo u_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (head),
      .status (fifo_status)
   );

   irpp_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .status (fifo_status),
      .pop    (pop),
      .rsp_if (rsp_if)
   );

`ifndef SYNTHESIS
   // A good frame never arrives at a full queue
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !fifo_status.full)
      else $error("frame pushed into full queue");

   // Back end only pops real frames
   a_pop_data: assert property (@(posedge clock) disable iff (reset)
      pop |-> !fifo_status.empty)
      else $error("pop from empty queue");

   // Queue status is consistent
   a_status: assert property (@(posedge clock) disable iff (reset)
      !(fifo_status.full && fifo_status.empty))
      else $error("queue both full and empty");

   // No result item straight after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_if.valid)
      else $error("result valid after reset");
`endif

endmodule
`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU RVC packet parser testbench
// Sends serial bytes to the parser as short directed frames, then as random
// frames, noise and broken headers. A byte-level tracker of the frame
// format predicts each decoded frame, which is checked field by field
// against the result channel. Both channels idle and stall in random bursts.
// ----------------------------------------------------------------------------
module testbench;
   import irpp_pkg::*;

   // One decoded frame as it should leave the block
   typedef struct packed {
      frame_type chans;
      count_type total;
   } decoded_type;

   localparam int QUIET_LIMIT = 2000;
   localparam int TAIL_ITEMS  = 150;
   localparam int RANDOM_BYTES = 1600;

   logic clock;
   logic reset;

   irpp_req_if req_ch ();
   irpp_rsp_if rsp_ch ();

   imu_rvc_packet_parser dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // Bytes waiting to be sent, frames waiting to come out
   byte_type    rx_pending [$];
   decoded_type frames_expected [$];

   // Frame tracker state
   phase_type trk_phase;
   pos_type   trk_pos;
   byte_type  trk_sum;
   byte_type  trk_chan [CHAN_BYTES];
   count_type trk_total;

   int  error_count = 0;
   int  bytes_sent  = 0;
   int  send_gap    = 0;
   int  stall_left  = 0;
   int  rsp_cycle   = 0;
   int  quiet_count = 0;
   bit  byte_taken  = 1'b0;

   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
   endtask

   // Advance the tracker by one accepted byte; queue a frame on a good checksum
   task automatic track_byte(input byte_type b);
      decoded_type d;
      case (trk_phase)
         PH_HUNT2: begin
            if (b == HDR_BYTE) begin
               trk_phase = PH_BODY;
               trk_pos   = '0;
               trk_sum   = '0;
            end else begin
               trk_phase = PH_HUNT1;
            end
         end
         PH_BODY: begin
            if (trk_pos < SUM_LEN) begin
               if (trk_pos >= 1 && trk_pos <= CHAN_BYTES)
                  trk_chan[trk_pos - 1] = b;
               trk_sum = trk_sum + b;
               trk_pos = trk_pos + 1'b1;
            end else begin
               trk_phase = PH_HUNT1;
               trk_pos   = '0;
               if (b == trk_sum) begin
                  trk_total = trk_total + 1'b1;
                  d.chans.yaw_raw     = {trk_chan[1],  trk_chan[0]};
                  d.chans.pitch_raw   = {trk_chan[3],  trk_chan[2]};
                  d.chans.roll_raw    = {trk_chan[5],  trk_chan[4]};
                  d.chans.accel_x_raw = {trk_chan[7],  trk_chan[6]};
                  d.chans.accel_y_raw = {trk_chan[9],  trk_chan[8]};
                  d.chans.accel_z_raw = {trk_chan[11], trk_chan[10]};
                  d.total = trk_total;
                  frames_expected.push_back(d);
               end
               trk_sum = '0;
            end
         end
         default: begin
            if (b == HDR_BYTE)
               trk_phase = PH_HUNT2;
         end
      endcase
   endtask

   // Header, sixteen payload bytes (byte 0 in the low bits), then the checksum
   task automatic queue_frame(input logic [16*BYTE_W-1:0] body, input bit good);
      byte_type acc;
      acc = '0;
      rx_pending.push_back(HDR_BYTE);
      rx_pending.push_back(HDR_BYTE);
      for (int i = 0; i < 16; i++) begin
         acc = acc + body[i*BYTE_W +: BYTE_W];
         rx_pending.push_back(body[i*BYTE_W +: BYTE_W]);
      end
      if (good)
         rx_pending.push_back(acc);
      else
         rx_pending.push_back(acc ^ byte_type'($urandom_range(1, 255)));
   endtask

   function automatic byte_type pick_byte(input bit extreme);
      if (!extreme)
         return byte_type'($urandom);
      case ($urandom_range(0, 4))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h80;
         3: return 8'h7F;
         default: return HDR_BYTE;
      endcase
   endfunction

   function automatic logic [16*BYTE_W-1:0] random_body(input bit extreme);
      logic [16*BYTE_W-1:0] body;
      for (int i = 0; i < 16; i++)
         body[i*BYTE_W +: BYTE_W] = pick_byte(extreme);
      return body;
   endfunction

   // Byte driver: holds an item until taken, idles in bursts
   always @(negedge clock) begin
      if (!reset && (!req_ch.valid || byte_taken)) begin
         byte_taken = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
            req_ch.valid <= 1'b0;
         end else if (rx_pending.size() == 0) begin
            req_ch.valid <= 1'b0;
         end else if (rx_pending.size() > TAIL_ITEMS && ((bytes_sent >> 7) % 3) != 2 &&
                      $urandom_range(0, 15) == 0) begin
            send_gap = $urandom_range(1, 10) - 1;
            req_ch.valid <= 1'b0;
         end else begin
            req_ch.valid   <= 1'b1;
            req_ch.rx_byte <= rx_pending.pop_front();
            bytes_sent++;
         end
      end
   end

   // Result receiver: stalls in bursts, none in the tail
   always @(negedge clock) begin
      if (!reset) begin
         rsp_cycle++;
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (rx_pending.size() > TAIL_ITEMS && ((rsp_cycle >> 8) % 3) != 2 &&
                      $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 10) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Monitor: check results, then track accepted bytes
   always @(posedge clock) begin
      decoded_type want;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (frames_expected.size() == 0) begin
               report_mismatch("frame out with none expected");
            end else begin
               want = frames_expected.pop_front();
               check_field("yaw_raw",      rsp_ch.yaw_raw,      want.chans.yaw_raw);
               check_field("pitch_raw",    rsp_ch.pitch_raw,    want.chans.pitch_raw);
               check_field("roll_raw",     rsp_ch.roll_raw,     want.chans.roll_raw);
               check_field("accel_x_raw",  rsp_ch.accel_x_raw,  want.chans.accel_x_raw);
               check_field("accel_y_raw",  rsp_ch.accel_y_raw,  want.chans.accel_y_raw);
               check_field("accel_z_raw",  rsp_ch.accel_z_raw,  want.chans.accel_z_raw);
               check_field("good_packets", rsp_ch.good_packets, want.total);
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            track_byte(req_ch.rx_byte);
            byte_taken = 1'b1;
         end
      end
   end

   // Watchdog on cycles with no item moving on either channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_count = 0;
      end else begin
         quiet_count++;
         if (quiet_count >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // Stimulus and end of run
   initial begin
      int r;
      int n;
      int stop_at;
      clock          = 1'b0;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = '0;
      rsp_ch.ready   = 1'b0;
      trk_phase      = PH_HUNT1;
      trk_pos        = '0;
      trk_sum        = '0;
      trk_total      = '0;
      foreach (trk_chan[i])
         trk_chan[i] = '0;

      // Directed: byte extremes, a lone header, then a good frame holding
      // channel extremes and header bytes inside the payload
      rx_pending.push_back(8'h00);
      rx_pending.push_back(8'hFF);
      rx_pending.push_back(HDR_BYTE);
      rx_pending.push_back(8'h37);
      queue_frame({8'hAA, 8'h00, 8'hFF, 8'h00, 8'h01, 8'h00, 8'h00, 8'hAA,
                   8'hAA, 8'hFF, 8'hFF, 8'h7F, 8'hFF, 8'h80, 8'h00, 8'hAA}, 1'b1);

      // Random: mostly well-formed frames, some bad sums, noise and broken headers
      stop_at = rx_pending.size() + RANDOM_BYTES;
      while (rx_pending.size() < stop_at) begin
         r = $urandom_range(0, 19);
         if (r <= 12) begin
            queue_frame(random_body(r < 3), 1'b1);
         end else if (r <= 15) begin
            queue_frame(random_body(r == 15), 1'b0);
         end else if (r <= 17) begin
            n = $urandom_range(1, 6);
            repeat (n)
               rx_pending.push_back(($urandom_range(0, 2) == 0) ? HDR_BYTE : pick_byte(1'b0));
         end else if (r == 18) begin
            rx_pending.push_back(HDR_BYTE);
            rx_pending.push_back(HDR_BYTE ^ byte_type'($urandom_range(1, 255)));
         end else begin
            // truncated frame: the next bytes complete it as payload
            rx_pending.push_back(HDR_BYTE);
            rx_pending.push_back(HDR_BYTE);
            n = $urandom_range(1, 16);
            repeat (n)
               rx_pending.push_back(pick_byte(1'b0));
         end
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (rx_pending.size() != 0 || req_ch.valid)
         @(posedge clock);
      while (frames_expected.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (frames_expected.size() != 0)
         report_mismatch($sformatf("%0d frames never came out", frames_expected.size()));
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
